// ===== design/lpdr_pkg.sv =====
// Shared types, constants and constant-divide helpers for the light pulse
// distance receiver. No dependencies.
package lpdr_pkg;

  // Field widths
  localparam int SampleW = 10;
  localparam int TimeW   = 32;
  localparam int DurW    = 15;
  localparam int ByteW   = 8;
  localparam int IdxW    = 7;
  localparam int ThHiW   = 10;
  localparam int ThLoW   = 11;
  localparam int CalMinW = 11;

  // Timing limits in ms
  localparam logic [TimeW-1:0] LeaderMs = 32'd800;
  localparam logic [TimeW-1:0] OneMs    = 32'd200;

  // Reset values
  localparam logic [SampleW-1:0] ThHighRst = 10'd700;
  localparam logic [SampleW-1:0] ThLowRst  = 10'd100;
  localparam logic [CalMinW-1:0] CalMinRst = 11'd1024;

  // Defaults for top-level parameters
  localparam int MaxBytesDef   = 64;
  localparam int QueueDepthDef = 4;

  // Configuration register indexes
  localparam logic RegThHigh = 1'b0;
  localparam logic RegThLow  = 1'b1;

  typedef enum logic [2:0] {
    EV_BYTE     = 3'd0,
    EV_LEADER   = 3'd1,
    EV_CAL_DONE = 3'd2,
    EV_CAL_ERR  = 3'd3,
    EV_DROP     = 3'd4
  } lpdr_ev_e;

  // Result command passed from front to back through the queue
  typedef struct packed {
    lpdr_ev_e         ev;
    logic [ByteW-1:0] data;
    logic [IdxW-1:0]  idx;
    logic [ThHiW-1:0] th;
    logic [ThLoW-1:0] tl;
  } lpdr_cmd_t;

  // floor(m*4/5): reciprocal 3277/2^14, exact for m*4 < 4096
  function automatic logic [ThHiW-1:0] div5_x4(input logic [SampleW-1:0] m);
    logic [23:0] prod;
    prod = {2'b00, m, 2'b00} * 24'd3277;
    return prod[23:14];
  endfunction

  // floor(m*6/5): reciprocal 3277/2^14, exact for m*6 <= 6144
  function automatic logic [ThLoW-1:0] div5_x6(input logic [CalMinW-1:0] m);
    logic [12:0] m6;
    logic [24:0] prod;
    m6   = {m, 2'b00} + {1'b0, m, 1'b0};
    prod = {12'd0, m6} * 25'd3277;
    return prod[24:14];
  endfunction

  // floor(t/3): reciprocal 43691/2^17, exact for t < 1024
  function automatic logic [ThLoW-1:0] div3(input logic [ThHiW-1:0] t);
    logic [25:0] prod;
    prod = {16'd0, t} * 26'd43691;
    return {2'b00, prod[25:17]};
  endfunction

endpackage

// ===== design/lpdr_fifo.sv =====
// Small register FIFO carrying result commands from front to back.
// No package dependencies.
module lpdr_fifo #(
  parameter int Width = 8,
  parameter int Depth = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             ready_o,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             valid_o
);
  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wptr_q, rptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_push, do_pop;

  assign ready_o = (cnt_q != CntFull);
  assign valid_o = (cnt_q != '0);
  assign rdata_o = mem_q[rptr_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == PtrLast) ? '0 : wptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == PtrLast) ? '0 : rptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (!do_push && do_pop) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

// ===== design/lpdr_front.sv =====
// Front end: accepts items, runs hysteresis, edge timing, bit/byte assembly
// and calibration, and pushes result commands. Depends on lpdr_pkg.
module lpdr_front import lpdr_pkg::*; #(
  parameter int MaxBytes = MaxBytesDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [SampleW-1:0] cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               req_type_i,
  input  logic [SampleW-1:0] sample_i,
  input  logic [TimeW-1:0]   now_ms_i,
  input  logic [DurW-1:0]    cal_duration_ms_i,
  input  logic               q_ready_i,
  output logic               q_push_o,
  output lpdr_cmd_t          q_cmd_o
);
  localparam int CntW = $clog2(MaxBytes + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MaxBytes);

  typedef enum logic [1:0] {
    CAL_IDLE,
    CAL_MUL,
    CAL_FIN
  } cal_st_e;

  cal_st_e            cal_st_q, cal_st_d;
  logic [SampleW-1:0] act_high_q, act_high_d;
  logic [SampleW-1:0] act_low_q, act_low_d;
  logic               prev_q, prev_d;
  logic [TimeW-1:0]   last_edge_q, last_edge_d;
  logic [ByteW-1:0]   shift_q, shift_d;
  logic [2:0]         bit_cnt_q, bit_cnt_d;
  logic [CntW-1:0]    byte_cnt_q, byte_cnt_d;
  logic               calib_q, calib_d;
  logic [TimeW-1:0]   cal_start_q, cal_start_d;
  logic [DurW-1:0]    cal_len_q, cal_len_d;
  logic [SampleW-1:0] cal_max_q, cal_max_d;
  logic [CalMinW-1:0] cal_min_q, cal_min_d;
  logic [ThHiW-1:0]   th_q, th_d;
  logic [ThLoW-1:0]   tl6_q, tl6_d;

  logic             accept;
  logic             is_high, is_low;
  logic [TimeW-1:0] diff, cal_elapsed;
  logic [ByteW-1:0] nshift;
  logic [ThLoW-1:0] tl;

  assign in_ready_o  = q_ready_i && (cal_st_q == CAL_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign is_high     = sample_i > act_high_q;
  assign is_low      = sample_i < act_low_q;
  assign diff        = now_ms_i - last_edge_q;
  assign cal_elapsed = now_ms_i - cal_start_q;
  assign nshift      = {shift_q[ByteW-2:0], (diff > OneMs)};
  assign tl          = (cal_min_q == '0) ? div3(th_q) : tl6_q;

  always_comb begin
    cal_st_d    = cal_st_q;
    act_high_d  = act_high_q;
    act_low_d   = act_low_q;
    prev_d      = prev_q;
    last_edge_d = last_edge_q;
    shift_d     = shift_q;
    bit_cnt_d   = bit_cnt_q;
    byte_cnt_d  = byte_cnt_q;
    calib_d     = calib_q;
    cal_start_d = cal_start_q;
    cal_len_d   = cal_len_q;
    cal_max_d   = cal_max_q;
    cal_min_d   = cal_min_q;
    th_d        = th_q;
    tl6_d       = tl6_q;
    q_push_o    = 1'b0;
    q_cmd_o     = '{ev: EV_BYTE, data: shift_q, idx: IdxW'(byte_cnt_q), th: th_q, tl: tl};

    unique case (cal_st_q)
      CAL_IDLE: begin
        if (accept) begin
          if (req_type_i) begin
            calib_d     = 1'b1;
            cal_start_d = now_ms_i;
            cal_len_d   = cal_duration_ms_i;
            cal_max_d   = '0;
            cal_min_d   = CalMinRst;
          end else if (calib_q) begin
            cal_max_d = (sample_i > cal_max_q) ? sample_i : cal_max_q;
            cal_min_d = ({1'b0, sample_i} < cal_min_q) ? {1'b0, sample_i} : cal_min_q;
            if (cal_elapsed >= {{(TimeW-DurW){1'b0}}, cal_len_q}) begin
              calib_d  = 1'b0;
              cal_st_d = CAL_MUL;
            end
          end else if (is_high || is_low) begin
            prev_d = is_high;
            if (is_high && !prev_q) begin
              last_edge_d = now_ms_i;
              if (diff > LeaderMs) begin
                q_push_o    = 1'b1;
                q_cmd_o.ev  = EV_LEADER;
                byte_cnt_d  = '0;
                shift_d     = '0;
                bit_cnt_d   = '0;
              end else if (bit_cnt_q == 3'd7) begin
                // byte complete
                q_push_o     = 1'b1;
                q_cmd_o.data = nshift;
                shift_d      = '0;
                bit_cnt_d    = '0;
                if (byte_cnt_q < CntMax) begin
                  q_cmd_o.ev = EV_BYTE;
                  byte_cnt_d = byte_cnt_q + CntW'(1);
                end else begin
                  q_cmd_o.ev = EV_DROP;
                end
              end else begin
                shift_d   = nshift;
                bit_cnt_d = bit_cnt_q + 3'd1;
              end
            end
          end
        end
      end
      CAL_MUL: begin
        th_d     = div5_x4(cal_max_q);
        tl6_d    = div5_x6(cal_min_q);
        cal_st_d = CAL_FIN;
      end
      CAL_FIN: begin
        if (q_ready_i) begin
          q_push_o = 1'b1;
          cal_st_d = CAL_IDLE;
          if (tl >= {1'b0, th_q}) begin
            q_cmd_o.ev = EV_CAL_ERR;
          end else begin
            q_cmd_o.ev = EV_CAL_DONE;
            act_high_d = th_q;
            act_low_d  = tl[SampleW-1:0];
          end
        end
      end
      default: cal_st_d = CAL_IDLE;
    endcase

    // The user must make register writes only while idle; the block does not enforce it
    if (cfg_we_i) begin
      if (cfg_idx_i == RegThHigh) begin
        act_high_d = cfg_wdata_i;
      end else if (cfg_idx_i == RegThLow) begin
        act_low_d = cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_st_q    <= CAL_IDLE;
      act_high_q  <= ThHighRst;
      act_low_q   <= ThLowRst;
      prev_q      <= 1'b0;
      last_edge_q <= '0;
      shift_q     <= '0;
      bit_cnt_q   <= '0;
      byte_cnt_q  <= '0;
      calib_q     <= 1'b0;
      cal_start_q <= '0;
      cal_len_q   <= '0;
      cal_max_q   <= '0;
      cal_min_q   <= CalMinRst;
    end else begin
      cal_st_q    <= cal_st_d;
      act_high_q  <= act_high_d;
      act_low_q   <= act_low_d;
      prev_q      <= prev_d;
      last_edge_q <= last_edge_d;
      shift_q     <= shift_d;
      bit_cnt_q   <= bit_cnt_d;
      byte_cnt_q  <= byte_cnt_d;
      calib_q     <= calib_d;
      cal_start_q <= cal_start_d;
      cal_len_q   <= cal_len_d;
      cal_max_q   <= cal_max_d;
      cal_min_q   <= cal_min_d;
    end
  end

  always_ff @(posedge clk_i) begin
    th_q  <= th_d;
    tl6_q <= tl6_d;
  end

endmodule

// ===== design/lpdr_back.sv =====
// Back end: pops result commands, zeroes the fields an event does not use,
// and holds the result in the output register. Depends on lpdr_pkg.
module lpdr_back import lpdr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  input  lpdr_cmd_t        q_cmd_i,
  output logic             q_pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [2:0]       event_res_o,
  output logic [ByteW-1:0] data_byte_o,
  output logic [IdxW-1:0]  byte_index_o,
  output logic [ThHiW-1:0] new_thresh_high_o,
  output logic [ThLoW-1:0] new_thresh_low_o
);
  logic             out_valid_q;
  logic [2:0]       ev_q;
  logic [ByteW-1:0] data_q, data_d;
  logic [IdxW-1:0]  idx_q, idx_d;
  logic [ThHiW-1:0] th_q, th_d;
  logic [ThLoW-1:0] tl_q, tl_d;

  assign q_pop_o = q_valid_i && (!out_valid_q || out_ready_i);

  always_comb begin
    data_d = '0;
    idx_d  = '0;
    th_d   = '0;
    tl_d   = '0;
    unique case (q_cmd_i.ev)
      EV_BYTE, EV_DROP: begin
        data_d = q_cmd_i.data;
        idx_d  = q_cmd_i.idx;
      end
      EV_LEADER: idx_d = q_cmd_i.idx;
      EV_CAL_DONE, EV_CAL_ERR: begin
        th_d = q_cmd_i.th;
        tl_d = q_cmd_i.tl;
      end
      default: data_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (q_pop_o) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      ev_q   <= q_cmd_i.ev;
      data_q <= data_d;
      idx_q  <= idx_d;
      th_q   <= th_d;
      tl_q   <= tl_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign event_res_o       = ev_q;
  assign data_byte_o       = data_q;
  assign byte_index_o      = idx_q;
  assign new_thresh_high_o = th_q;
  assign new_thresh_low_o  = tl_q;

endmodule

// ===== design/light_pulse_distance_receiver.sv =====
// Light pulse distance receiver: top level tying front, result queue and back.
// Depends on lpdr_pkg, lpdr_front, lpdr_fifo, lpdr_back.

// The block takes one item per clock: a timestamped light sample, or a
// request to start calibration. Outside calibration each sample is sliced
// by hysteresis thresholds; a rising edge measures the time since the last
// one: over 800 ms is a leader (reports the frame's byte count, event 1),
// over 200 ms a one bit, else a zero bit. Bits fill bytes MSB first; each
// full byte comes out as event 0 with its index, or event 4 once the frame
// already holds MaxBytes bytes. During calibration samples feed a min/max
// tracker; when the duration has elapsed the new thresholds are worked out
// and reported as event 2 (applied) or event 3 (rejected, low >= high).
// Rate: one item per cycle while in_ready is high. The sample that ends
// calibration holds in_ready low while the threshold math runs through its
// registered multiply step (CAL_MUL) and the compare and queue write (CAL_FIN).
// in_ready also drops while the QueueDepth-entry result queue between the
// front end and the output register is full, which only happens when
// out_ready stays low. A result passes through the queue write, then the
// output register; a calibration result first passes CAL_MUL and CAL_FIN.
// Register writes (index 0 high threshold, 1 low threshold) load the active
// thresholds at once and are expected only while the block is idle.
module light_pulse_distance_receiver import lpdr_pkg::*; #(
  parameter int MaxBytes   = MaxBytesDef,
  parameter int QueueDepth = QueueDepthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration write port
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [SampleW-1:0] cfg_wdata_i,
  // input items
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               req_type_i,
  input  logic [SampleW-1:0] sample_i,
  input  logic [TimeW-1:0]   now_ms_i,
  input  logic [DurW-1:0]    cal_duration_ms_i,
  // result items
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [2:0]         event_res_o,
  output logic [ByteW-1:0]   data_byte_o,
  output logic [IdxW-1:0]    byte_index_o,
  output logic [ThHiW-1:0]   new_thresh_high_o,
  output logic [ThLoW-1:0]   new_thresh_low_o
);
  localparam int CmdW = $bits(lpdr_cmd_t);

  lpdr_cmd_t        push_cmd, pop_cmd;
  logic [CmdW-1:0]  pop_bits;
  logic             q_push, q_ready, q_pop, q_valid;

  // Front: all per-item state, one transfer per cycle while in_ready is high
  lpdr_front #(
    .MaxBytes (MaxBytes)
  ) u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .req_type_i        (req_type_i),
    .sample_i          (sample_i),
    .now_ms_i          (now_ms_i),
    .cal_duration_ms_i (cal_duration_ms_i),
    .q_ready_i         (q_ready),
    .q_push_o          (q_push),
    .q_cmd_o           (push_cmd)
  );

  // Result queue decouples front from output stalls
  lpdr_fifo #(
    .Width (CmdW),
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (push_cmd),
    .ready_o (q_ready),
    .pop_i   (q_pop),
    .rdata_o (pop_bits),
    .valid_o (q_valid)
  );

  assign pop_cmd = lpdr_cmd_t'(pop_bits);

  // Back: result formatting and output register
  lpdr_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .q_valid_i         (q_valid),
    .q_cmd_i           (pop_cmd),
    .q_pop_o           (q_pop),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .event_res_o       (event_res_o),
    .data_byte_o       (data_byte_o),
    .byte_index_o      (byte_index_o),
    .new_thresh_high_o (new_thresh_high_o),
    .new_thresh_low_o  (new_thresh_low_o)
  );

endmodule
